>>> rtl/lmdbp_pkg.sv
package lmdbp_pkg;

    localparam int HALF_WINDOW_DEF = 2;
    localparam int COORD_BITS_DEF  = 12;

    // wide enough for window ages and counts at any allowed half window
    localparam int IDX_W = 4;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_K0_COL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_K0_ROW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_K0_OFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_K1_COL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_K1_ROW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_K1_OFF = 3'd5;

    localparam logic [31:0] K_ONE = 32'h0100_0000;

    // multiply sequence steps
    localparam logic [2:0] ST_X_COL = 3'd0;
    localparam logic [2:0] ST_X_ROW = 3'd1;
    localparam logic [2:0] ST_X_HI  = 3'd2;
    localparam logic [2:0] ST_X_LO  = 3'd3;
    localparam logic [2:0] ST_Y_COL = 3'd4;
    localparam logic [2:0] ST_Y_ROW = 3'd5;
    localparam logic [2:0] ST_Y_HI  = 3'd6;
    localparam logic [2:0] ST_Y_LO  = 3'd7;

    typedef struct packed {
        logic             shift;
        logic             load;
        logic             sort;
        logic             parity;
        logic             median;
        logic             mul;
        logic [2:0]       step;
        logic             push;
        logic [IDX_W-1:0] age;
        logic [IDX_W-1:0] hi;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

>>> rtl/lmdbp_ctrl.sv
module lmdbp_ctrl #(
    parameter int HALF_WINDOW = lmdbp_pkg::HALF_WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_missing,
    input  logic              i_end,
    input  lmdbp_pkg::t_status i_status,
    output logic              o_ready,
    output lmdbp_pkg::t_cmd   o_cmd
);
    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    localparam int VCW     = $clog2(WIN_LEN + 1);
    localparam int PCW     = $clog2(HALF_WINDOW + 2);
    localparam int CW      = ($clog2(WIN_LEN) > 3) ? $clog2(WIN_LEN) : 3;
    localparam int IW      = lmdbp_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_SORT, S_MED, S_MUL, S_PUSH
    } t_state;

    t_state          r_state, n_state;
    logic [VCW-1:0]  r_vc, n_vc;
    logic [PCW-1:0]  r_pc, n_pc;
    logic            r_end, n_end;
    logic            r_flush, n_flush;
    logic [IW-1:0]   r_age, n_age;
    logic [IW-1:0]   r_hi, n_hi;
    logic [CW-1:0]   r_cnt, n_cnt;

    logic            accept;
    logic [VCW-1:0]  vc_inc;
    logic [PCW-1:0]  pc_inc;

    // upper age of the window around a flushed point
    function automatic logic [IW-1:0] flush_hi(logic [IW-1:0] age, logic [VCW-1:0] vc);
        logic [IW-1:0] a;
        logic [IW-1:0] b;
        a = age + IW'(HALF_WINDOW);
        b = IW'(vc) - IW'(1);
        return (a > b) ? b : a;
    endfunction

    assign accept = (r_state == S_IDLE) && i_valid;
    assign vc_inc = (!i_missing && (r_vc < VCW'(WIN_LEN))) ? r_vc + VCW'(1) : r_vc;
    assign pc_inc = i_missing ? r_pc : r_pc + PCW'(1);

    always_comb begin
        n_state = r_state;
        n_vc    = r_vc;
        n_pc    = r_pc;
        n_end   = r_end;
        n_flush = r_flush;
        n_age   = r_age;
        n_hi    = r_hi;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_vc  = vc_inc;
                    n_pc  = pc_inc;
                    n_end = i_end;
                    n_cnt = '0;
                    if (!i_missing && (pc_inc > PCW'(HALF_WINDOW))) begin
                        n_age   = IW'(HALF_WINDOW);
                        n_hi    = IW'(vc_inc) - IW'(1);
                        n_flush = 1'b0;
                        n_pc    = PCW'(HALF_WINDOW);
                        n_state = S_LOAD;
                    end else if (i_end && (pc_inc != '0)) begin
                        n_age   = IW'(pc_inc) - IW'(1);
                        n_hi    = flush_hi(IW'(pc_inc) - IW'(1), vc_inc);
                        n_flush = 1'b1;
                        n_state = S_LOAD;
                    end else if (i_end) begin
                        n_vc = '0;
                        n_pc = '0;
                    end
                end
            end
            S_LOAD: n_state = S_SORT;
            S_SORT: begin
                if (r_cnt == CW'(WIN_LEN - 1)) begin
                    n_cnt   = '0;
                    n_state = S_MED;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_MED: begin
                n_cnt   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (r_cnt[2:0] == lmdbp_pkg::ST_Y_LO) begin
                    n_cnt   = '0;
                    n_state = S_PUSH;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    if (r_flush && (r_age != '0)) begin
                        n_age   = r_age - IW'(1);
                        n_hi    = flush_hi(r_age - IW'(1), r_vc);
                        n_state = S_LOAD;
                    end else if (!r_flush && r_end) begin
                        n_age   = IW'(HALF_WINDOW - 1);
                        n_hi    = flush_hi(IW'(HALF_WINDOW - 1), r_vc);
                        n_flush = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        if (r_end) begin
                            n_vc = '0;
                            n_pc = '0;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vc    <= '0;
            r_pc    <= '0;
            r_end   <= 1'b0;
            r_flush <= 1'b0;
            r_age   <= '0;
            r_hi    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_vc    <= n_vc;
            r_pc    <= n_pc;
            r_end   <= n_end;
            r_flush <= n_flush;
            r_age   <= n_age;
            r_hi    <= n_hi;
            r_cnt   <= n_cnt;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.shift  = accept && !i_missing;
        o_cmd.load   = (r_state == S_LOAD);
        o_cmd.sort   = (r_state == S_SORT);
        o_cmd.parity = r_cnt[0];
        o_cmd.median = (r_state == S_MED);
        o_cmd.mul    = (r_state == S_MUL);
        o_cmd.step   = r_cnt[2:0];
        o_cmd.push   = (r_state == S_PUSH) && i_status.out_free;
        o_cmd.age    = r_age;
        o_cmd.hi     = r_hi;
        o_cmd.last   = r_flush && (r_age == '0);
    end

endmodule

>>> rtl/lmdbp_dp.sv
module lmdbp_dp #(
    parameter int HALF_WINDOW = lmdbp_pkg::HALF_WINDOW_DEF,
    parameter int COORD_BITS  = lmdbp_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [11:0]                     i_col,
    input  logic [11:0]                     i_row,
    input  logic [23:0]                     i_depth,
    input  logic                            i_cfg_we,
    input  logic [lmdbp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                     i_cfg_data,
    input  lmdbp_pkg::t_cmd                 i_cmd,
    output lmdbp_pkg::t_status              o_status,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [31:0]                     o_x,
    output logic [31:0]                     o_y,
    output logic [23:0]                     o_z,
    output logic                            o_last
);
    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    localparam int AW      = $clog2(WIN_LEN);
    localparam int NW      = $clog2(WIN_LEN + 1);
    localparam int SXW     = 32 + COORD_BITS + 3;
    localparam int QW      = SXW + 2;

    logic signed [31:0]     r_k [6];
    logic [23:0]            r_wd [WIN_LEN];
    logic [COORD_BITS-1:0]  r_wc [WIN_LEN];
    logic [COORD_BITS-1:0]  r_wr [WIN_LEN];
    logic                   r_sv [WIN_LEN];
    logic [23:0]            r_sd [WIN_LEN];
    logic                   n_sv [WIN_LEN];
    logic [23:0]            n_sd [WIN_LEN];
    logic [COORD_BITS-1:0]  r_col, r_row;
    logic [NW-1:0]          r_n;
    logic                   r_last;
    logic [23:0]            r_med, n_med;
    logic [SXW-1:0]         r_acc;
    logic [QW-1:0]          r_q, q_sum;
    logic [31:0]            r_x, r_y, q_sat;
    logic                   r_ov;
    logic [31:0]            r_ox, r_oy;
    logic [23:0]            r_oz;
    logic                   r_ol;

    logic signed [31:0]     mul_a;
    logic [24:0]            mul_b;
    logic signed [56:0]     prod;
    logic signed [SXW-25:0] acc_hi;
    logic [AW-1:0]          mid;
    logic [24:0]            pair_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k[0] <= lmdbp_pkg::K_ONE;
            r_k[1] <= '0;
            r_k[2] <= '0;
            r_k[3] <= '0;
            r_k[4] <= lmdbp_pkg::K_ONE;
            r_k[5] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lmdbp_pkg::CFG_K0_COL: r_k[0] <= i_cfg_data;
                lmdbp_pkg::CFG_K0_ROW: r_k[1] <= i_cfg_data;
                lmdbp_pkg::CFG_K0_OFF: r_k[2] <= i_cfg_data;
                lmdbp_pkg::CFG_K1_COL: r_k[3] <= i_cfg_data;
                lmdbp_pkg::CFG_K1_ROW: r_k[4] <= i_cfg_data;
                lmdbp_pkg::CFG_K1_OFF: r_k[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window, newest at age 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            for (int i = WIN_LEN - 1; i > 0; i--) begin
                r_wd[i] <= r_wd[i-1];
                r_wc[i] <= r_wc[i-1];
                r_wr[i] <= r_wr[i-1];
            end
            r_wd[0] <= i_depth;
            r_wc[0] <= COORD_BITS'(i_col);
            r_wr[0] <= COORD_BITS'(i_row);
        end
    end

    // odd-even transposition pass; unused slots sort to the top
    always_comb begin
        for (int i = 0; i < WIN_LEN; i++) begin
            n_sv[i] = r_sv[i];
            n_sd[i] = r_sd[i];
        end
        for (int i = 0; i + 1 < WIN_LEN; i++) begin
            if ((i % 2) == int'(i_cmd.parity)) begin
                if ((!r_sv[i] && r_sv[i+1]) ||
                    (r_sv[i] && r_sv[i+1] && (r_sd[i] > r_sd[i+1]))) begin
                    n_sv[i]   = r_sv[i+1];
                    n_sd[i]   = r_sd[i+1];
                    n_sv[i+1] = r_sv[i];
                    n_sd[i+1] = r_sd[i];
                end
            end
        end
    end

    assign mid      = AW'((r_n - NW'(1)) >> 1);
    assign pair_sum = {1'b0, r_sd[mid]} + {1'b0, r_sd[(mid < AW'(WIN_LEN - 1)) ? mid + AW'(1) : mid]};
    assign n_med    = r_n[0] ? r_sd[mid] : pair_sum[24:1];

    assign acc_hi = r_acc[SXW-1:24];

    always_comb begin
        case (i_cmd.step)
            lmdbp_pkg::ST_X_COL: begin mul_a = r_k[0]; mul_b = 25'(r_col); end
            lmdbp_pkg::ST_X_ROW: begin mul_a = r_k[1]; mul_b = 25'(r_row); end
            lmdbp_pkg::ST_Y_COL: begin mul_a = r_k[3]; mul_b = 25'(r_col); end
            lmdbp_pkg::ST_Y_ROW: begin mul_a = r_k[4]; mul_b = 25'(r_row); end
            lmdbp_pkg::ST_X_HI, lmdbp_pkg::ST_Y_HI: begin
                mul_a = 32'(acc_hi);
                mul_b = {1'b0, r_med};
            end
            default: begin
                mul_a = {8'd0, r_acc[23:0]};
                mul_b = {1'b0, r_med};
            end
        endcase
    end

    assign prod  = mul_a * $signed(mul_b);
    assign q_sum = r_q + QW'(prod[47:24]);

    always_comb begin
        if (q_sum[QW-1:31] == '0 || q_sum[QW-1:31] == '1) begin
            q_sat = q_sum[31:0];
        end else begin
            q_sat = q_sum[QW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                r_sv[i] <= (i <= int'(i_cmd.hi));
                r_sd[i] <= r_wd[i];
            end
            r_col  <= r_wc[i_cmd.age[AW-1:0]];
            r_row  <= r_wr[i_cmd.age[AW-1:0]];
            r_n    <= NW'(i_cmd.hi) + NW'(1);
            r_last <= i_cmd.last;
        end
        if (i_cmd.sort) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                r_sv[i] <= n_sv[i];
                r_sd[i] <= n_sd[i];
            end
        end
        if (i_cmd.median) begin
            r_med <= n_med;
        end
        if (i_cmd.mul) begin
            case (i_cmd.step)
                lmdbp_pkg::ST_X_COL, lmdbp_pkg::ST_Y_COL: r_acc <= prod[SXW-1:0];
                lmdbp_pkg::ST_X_ROW: r_acc <= r_acc + prod[SXW-1:0] + SXW'(r_k[2]);
                lmdbp_pkg::ST_Y_ROW: r_acc <= r_acc + prod[SXW-1:0] + SXW'(r_k[5]);
                lmdbp_pkg::ST_X_HI, lmdbp_pkg::ST_Y_HI: r_q <= prod[QW-1:0];
                lmdbp_pkg::ST_X_LO: r_x <= q_sat;
                default: r_y <= q_sat;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.push) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_ox <= r_x;
            r_oy <= r_y;
            r_oz <= r_med;
            r_ol <= r_last;
        end
    end

    assign o_status.out_free = !r_ov || i_out_ready;
    assign o_out_valid       = r_ov;
    assign o_x               = r_ox;
    assign o_y               = r_oy;
    assign o_z               = r_oz;
    assign o_last            = r_ol;

endmodule

>>> rtl/line_median_depth_back_project.sv
// Sliding-median depth back-projection of one line region.
// Slave stream: one pixel per item; tdata holds col, row, depth; tuser is the
// missing-depth flag (item dropped); tlast marks the region end and flushes.
// Master stream: one point per item; tdata holds x, y, z; tlast is set on the
// last point of the region.
// Config: write-only port, index 0..5 selects the inverse matrix elements
// (row 0 col/row/offset, row 1 col/row/offset, Q8.24); write while idle.
// Sequence: an item that yields no point leaves the block idle. Each point
// runs load, one odd-even sort pass per window slot, median, eight steps of
// the shared 32x25 multiplier, then push. An item yields up to
// HALF_WINDOW+1 points; the next item is taken once its points are queued.
// A point is output HALF_WINDOW kept pixels after its own pixel.
// Reset clears counters and output valid, sets the identity matrix and keeps the window.
// A stalled receiver holds the output register; the block then waits with
// the next point ready and accepts no item.
module line_median_depth_back_project #(
    parameter int HALF_WINDOW = lmdbp_pkg::HALF_WINDOW_DEF,
    parameter int COORD_BITS  = lmdbp_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [47:0]                     i_s_axis_tdata, // pixel_col, pixel_row, depth_q
    input  logic                            i_s_axis_tuser, // depth_missing
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [87:0]                     o_m_axis_tdata, // point_x, point_y, point_z
    output logic                            o_m_axis_tlast,
    input  logic                            i_cfg_we,
    input  logic [lmdbp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                     i_cfg_data
);
    lmdbp_pkg::t_cmd    cmd;
    lmdbp_pkg::t_status status;
    logic [31:0] px, py;
    logic [23:0] pz;

    lmdbp_ctrl #(.HALF_WINDOW(HALF_WINDOW)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_missing (i_s_axis_tuser),
        .i_end     (i_s_axis_tlast),
        .i_status  (status),
        .o_ready   (o_s_axis_tready),
        .o_cmd     (cmd)
    );

    lmdbp_dp #(.HALF_WINDOW(HALF_WINDOW), .COORD_BITS(COORD_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_col       (i_s_axis_tdata[11:0]),
        .i_row       (i_s_axis_tdata[23:12]),
        .i_depth     (i_s_axis_tdata[47:24]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_x         (px),
        .o_y         (py),
        .o_z         (pz),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {pz, py, px};

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("point pushed over a waiting point");

    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load || cmd.sort || cmd.mul) |-> !o_s_axis_tready)
        else $error("item taken while a point is in work");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.shift, cmd.load, cmd.sort, cmd.median, cmd.mul, cmd.push}))
        else $error("datapath commands overlap");

endmodule

>>> tb/tb_line_median_depth_back_project.sv
`timescale 1ns / 100ps

class point_scoreboard;
    logic [31:0] inv_k [6];
    logic [23:0] win_dep [5];
    logic [11:0] win_col [5];
    logic [11:0] win_row [5];
    int unsigned kept_cnt;
    int unsigned wait_cnt;
    logic [88:0] pending_points [$];
    int unsigned mismatch_cnt;

    function new();
        reset_state();
    endfunction

    function void reset_state();
        for (int i = 0; i < 5; i++) begin
            win_dep[i] = '0;
            win_col[i] = '0;
            win_row[i] = '0;
        end
        kept_cnt = 0;
        wait_cnt = 0;
        inv_k[0] = lmdbp_pkg::K_ONE;
        inv_k[1] = '0;
        inv_k[2] = '0;
        inv_k[3] = '0;
        inv_k[4] = lmdbp_pkg::K_ONE;
        inv_k[5] = '0;
    endfunction

    function logic [23:0] window_median(int unsigned lo, int unsigned hi);
        logic [23:0] v [5];
        logic [23:0] t;
        int unsigned n;
        logic [24:0] s;
        n = 0;
        for (int unsigned i = lo; i <= hi && i < 5; i++) begin
            v[n] = win_dep[i];
            n++;
        end
        if (n == 0) return '0;
        for (int a = 0; a < n; a++)
            for (int b = 0; b + 1 < n - a; b++)
                if (v[b] > v[b + 1]) begin
                    t = v[b]; v[b] = v[b + 1]; v[b + 1] = t;
                end
        if (n % 2) return v[(n - 1) / 2];
        s = {1'b0, v[n / 2]} + {1'b0, v[n / 2 - 1]};
        return s[24:1];
    endfunction

    // floor(s*d / 2^24), clamped to int32
    function logic [31:0] scale_clamp(logic signed [47:0] s, logic [23:0] d);
        logic signed [79:0] p;
        logic signed [79:0] q;
        p = s * $signed({1'b0, d});
        q = p >>> 24;
        if (q > 80'sd2147483647) return 32'h7FFF_FFFF;
        if (q < -80'sd2147483648) return 32'h8000_0000;
        return q[31:0];
    endfunction

    function void push_point(int unsigned age, int unsigned lo, int unsigned hi,
                             bit last);
        logic [23:0] d;
        logic signed [47:0] sx, sy;
        logic [88:0] pt;
        d = window_median(lo, hi);
        sx = $signed(inv_k[0]) * $signed({1'b0, win_col[age]})
           + $signed(inv_k[1]) * $signed({1'b0, win_row[age]}) + $signed(inv_k[2]);
        sy = $signed(inv_k[3]) * $signed({1'b0, win_col[age]})
           + $signed(inv_k[4]) * $signed({1'b0, win_row[age]}) + $signed(inv_k[5]);
        pt = {last, d, scale_clamp(sy, d), scale_clamp(sx, d)};
        pending_points = {pending_points, pt};
    endfunction

    function void note_pixel(logic [47:0] data, bit missing, bit region_end);
        int unsigned hi, lo, age;
        if (!missing) begin
            for (int i = 4; i > 0; i--) begin
                win_dep[i] = win_dep[i - 1];
                win_col[i] = win_col[i - 1];
                win_row[i] = win_row[i - 1];
            end
            win_col[0] = data[11:0];
            win_row[0] = data[23:12];
            win_dep[0] = data[47:24];
            if (kept_cnt < 5) kept_cnt++;
            wait_cnt++;
            if (wait_cnt > 2) begin
                hi = (kept_cnt - 1 > 4) ? 4 : kept_cnt - 1;
                push_point(2, 0, hi, 1'b0);
                wait_cnt = 2;
            end
        end
        if (region_end) begin
            for (int a = wait_cnt; a > 0; a--) begin
                age = a - 1;
                lo = (age > 2) ? age - 2 : 0;
                hi = age + 2;
                if (kept_cnt == 0) hi = 0;
                else if (hi > kept_cnt - 1) hi = kept_cnt - 1;
                push_point(age, lo, hi, age == 0);
            end
            kept_cnt = 0;
            wait_cnt = 0;
        end
    endfunction

    function void check_point(logic [87:0] data, logic last);
        logic [88:0] exp_pt;
        if (pending_points.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("unexpected point: data=%h last=%b", data, last);
            return;
        end
        exp_pt = pending_points.pop_front();
        if (exp_pt[31:0] !== data[31:0] || exp_pt[63:32] !== data[63:32]
            || exp_pt[87:64] !== data[87:64] || exp_pt[88] !== last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("point mismatch: exp x=%h y=%h z=%h last=%b, got x=%h y=%h z=%h last=%b",
                         exp_pt[31:0], exp_pt[63:32], exp_pt[87:64], exp_pt[88],
                         data[31:0], data[63:32], data[87:64], last);
        end
    endfunction
endclass

module tb_line_median_depth_back_project;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;   // pixel_col, pixel_row, depth_q
    logic        i_s_axis_tuser = 1'b0; // depth_missing
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [87:0] o_m_axis_tdata;        // point_x, point_y, point_z
    logic        o_m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [lmdbp_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    point_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len = 0;
    int hold_off = 0;
    bit hold_taken = 1'b0;
    int unsigned cycle_cnt = 0;
    localparam int unsigned CYCLE_LIMIT = 400000;

    line_median_depth_back_project uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off when requested
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_point(o_m_axis_tdata, o_m_axis_tlast);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_axis_tready <= 1'b0;
        end else if (hold_len > 0 && !hold_taken) begin
            hold_off <= hold_len;
            hold_taken <= 1'b1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                              input logic [23:0] dep, input bit missing,
                              input bit region_end);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {dep, row, col};
        i_s_axis_tuser <= missing;
        i_s_axis_tlast <= region_end;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_pixel({dep, row, col}, missing, region_end);
    endtask

    task automatic write_reg(input logic [lmdbp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.inv_k[idx] = val;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_points.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_region(input int len, input bit big);
        logic [23:0] d;
        for (int i = 0; i < len; i++) begin
            d = big ? 24'($urandom()) : 24'($urandom_range(4095));
            if ($urandom_range(3) == 0) d = 24'($urandom());
            send_pixel(12'($urandom()), 12'($urandom()), d, $urandom_range(9) == 0,
                       i == len - 1);
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 23;
        recv_idle_pct = 80;

        // directed: reset matrix, extremes, short regions, missing+end, empty end
        send_pixel(12'hFFF, 12'hFFF, 24'hFFFFFF, 1'b0, 1'b1);
        send_pixel(12'h000, 12'h000, 24'h000000, 1'b0, 1'b0);
        send_pixel(12'h800, 12'h001, 24'h000100, 1'b0, 1'b1);
        send_pixel(12'd5, 12'd6, 24'h100, 1'b0, 1'b0);
        send_pixel(12'd7, 12'd8, 24'h300, 1'b0, 1'b0);
        send_pixel(12'd9, 12'd10, 24'h200, 1'b0, 1'b0);
        send_pixel(12'd11, 12'd12, 24'h900, 1'b0, 1'b0);
        send_pixel(12'd13, 12'd14, 24'h050, 1'b1, 1'b0);
        send_pixel(12'd15, 12'd16, 24'h700, 1'b0, 1'b0);
        send_pixel(12'd17, 12'd18, 24'h010, 1'b1, 1'b1);
        send_pixel(12'd1, 12'd1, 24'h1, 1'b1, 1'b1);
        send_pixel(12'd1, 12'd1, 24'h1, 1'b1, 1'b0);
        send_pixel(12'd3, 12'd4, 24'h400, 1'b0, 1'b0);
        send_pixel(12'd3, 12'd4, 24'h600, 1'b0, 1'b0);
        send_pixel(12'd3, 12'd4, 24'h500, 1'b0, 1'b0);
        send_pixel(12'd3, 12'd4, 24'h800, 1'b0, 1'b1);
        drain();

        // saturation extremes
        write_reg(lmdbp_pkg::CFG_K0_COL, 32'h7FFF_FFFF);
        write_reg(lmdbp_pkg::CFG_K0_ROW, 32'h7FFF_FFFF);
        write_reg(lmdbp_pkg::CFG_K0_OFF, 32'h7FFF_FFFF);
        write_reg(lmdbp_pkg::CFG_K1_COL, 32'h8000_0000);
        write_reg(lmdbp_pkg::CFG_K1_ROW, 32'h8000_0000);
        write_reg(lmdbp_pkg::CFG_K1_OFF, 32'h8000_0000);
        send_pixel(12'hFFF, 12'hFFF, 24'hFFFFFF, 1'b0, 1'b0);
        send_pixel(12'h001, 12'h000, 24'h000001, 1'b0, 1'b0);
        send_pixel(12'h000, 12'hFFF, 24'h7FFFFF, 1'b0, 1'b1);
        drain();

        // long receiver hold-off with sender pushing
        send_idle_pct = 0;
        hold_len = 300;
        random_region(12, 1'b1);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 23 : 0;
            for (int r = 0; r < 4; r++) begin
                for (int k = 0; k < 6; k++)
                    write_reg(k[lmdbp_pkg::CFG_IDX_W-1:0],
                              ($urandom_range(1) == 0) ? $urandom()
                                  : $urandom_range(32'h0200_0000));
                for (int g = 0; g < 3; g++)
                    random_region($urandom_range(1, 9), 1'($urandom_range(1)));
                drain();
            end
        end

        write_reg(lmdbp_pkg::CFG_K0_COL, 32'h0);
        write_reg(lmdbp_pkg::CFG_K0_ROW, 32'h0);
        write_reg(lmdbp_pkg::CFG_K0_OFF, 32'hFFFF_FFFF);
        write_reg(lmdbp_pkg::CFG_K1_COL, 32'h0);
        write_reg(lmdbp_pkg::CFG_K1_ROW, 32'h0);
        write_reg(lmdbp_pkg::CFG_K1_OFF, 32'h0000_0001);
        random_region(6, 1'b1);
        drain();
        repeat (100) @(posedge i_clk);

        if (sb.mismatch_cnt == 0 && sb.pending_points.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

>>> files.f
rtl/lmdbp_pkg.sv
rtl/lmdbp_ctrl.sv
rtl/lmdbp_dp.sv
rtl/line_median_depth_back_project.sv
tb/tb_line_median_depth_back_project.sv
